### src/pmct_pkg.sv
// Shared constants, types and helper functions for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package pmct_pkg;

   // Largest usable screen size in pixels per axis.
   localparam int COORD_LIMIT = 4096;

   localparam int BYTE_W    = 8;
   localparam int SIZE_W    = 13;
   localparam int POS_W     = 12;
   localparam int DELTA_W   = 9;
   localparam int BTN_W     = 3;
   localparam int CSR_IDX_W = 4;

   // Effective size holds 1..COORD_LIMIT, the cursor 0..COORD_LIMIT-1.
   localparam int EFF_W = $clog2(COORD_LIMIT + 1);
   localparam int CUR_W = $clog2(COORD_LIMIT);
   localparam int SUM_W = ((EFF_W > DELTA_W) ? EFF_W : DELTA_W) + 2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   // Header byte bit positions.
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;
   localparam int HDR_X_OVF  = 6;
   localparam int HDR_Y_OVF  = 7;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      IDX_HEADER,
      IDX_X,
      IDX_Y
   } byte_idx_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_mag;
      logic [BYTE_W-1:0] y_mag;
   } packet_type;

   function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [EFF_W-1:0] r;
      if (v == '0) begin
         r = EFF_W'(1);
      end else if (32'(v) > 32'(COORD_LIMIT)) begin
         r = EFF_W'(COORD_LIMIT);
      end else begin
         r = EFF_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CUR_W-1:0] half_size(input logic [EFF_W-1:0] eff);
      return CUR_W'(eff >> 1);
   endfunction

   // Zero magnitude stays zero whatever the sign bit says.
   function automatic logic signed [DELTA_W-1:0] decode_delta(
      input logic [BYTE_W-1:0] mag,
      input logic              neg
   );
      return $signed({neg && (mag != '0), mag});
   endfunction

   function automatic logic [CUR_W-1:0] clamp_coord(
      input logic [CUR_W-1:0]          cur,
      input logic signed [DELTA_W-1:0] delta,
      input logic [EFF_W-1:0]          eff
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] lim;
      logic signed [SUM_W-1:0] r;
      sum = $signed(SUM_W'(cur)) + SUM_W'(delta);
      lim = $signed(SUM_W'(eff)) - SUM_W'(1);
      r = (sum > lim) ? lim : sum;
      if (r < 0) begin
         r = '0;
      end
      return CUR_W'(r);
   endfunction

endpackage

`default_nettype wire

### src/ps2_mouse_packet_cursor_tracker_top.sv
// PS/2 mouse packet cursor tracker, top level.
// Depends on pmct_pkg, pmct_framer and pmct_cursor.
//
// Usage:
//   req_*  : one raw mouse byte per request. Bytes group in threes (header,
//            X magnitude, Y magnitude); the sync bit is not checked.
//   rsp_*  : one response per third byte: clamped cursor position, the
//            applied deltas (Y negated, both zero on overflow) and buttons.
//   csr_*  : size register writes (index 0 width, 1 height), always ready.
//            Any size write recenters the cursor; other indexes are ignored.
// Timing:
//   A byte is held in the input register and the packet result is registered
//   when the Y byte is taken, so a response follows the third byte through
//   both registers. One byte per cycle is sustained while responses are taken;
//   only delta decode and the per-axis cursor add and clamp lie between them.
// Reset:
//   Clears the byte count, sets 640 x 480 and centers the cursor at 320, 240.
// Stall:
//   A held response keeps its value; the input register still takes header
//   and X bytes, and the Y byte waits there until the response is taken.
`default_nettype none

module ps2_mouse_packet_cursor_tracker_top
   import pmct_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [POS_W-1:0]     rsp_pos_x,
   output      logic [POS_W-1:0]     rsp_pos_y,
   output      logic signed [DELTA_W-1:0] rsp_delta_x,
   output      logic signed [DELTA_W-1:0] rsp_delta_y,
   output      logic [BTN_W-1:0]     rsp_button_bits,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data
);

   packet_type pkt;
   logic       pkt_ready;

   assign csr_ready = 1'b1;

   pmct_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .pkt           (pkt),
      .pkt_ready     (pkt_ready)
   );

   pmct_cursor u_cursor (
      .clock           (clock),
      .reset           (reset),
      .pkt             (pkt),
      .pkt_ready       (pkt_ready),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_button_bits (rsp_button_bits)
   );

endmodule

`default_nettype wire

### src/pmct_framer.sv
// Input register and three-byte packet framer of the PS/2 mouse cursor tracker.
// Depends on pmct_pkg; feeds pmct_cursor with one packet per third byte.
`default_nettype none

module pmct_framer
   import pmct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   output      packet_type        pkt,
   input  wire logic              pkt_ready
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   byte_idx_type      idx_ff, idx_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] x_mag_ff, x_mag_in;
   logic              advance;
   logic              accept;

   // Header and X bytes retire at once; the Y byte waits for the cursor stage.
   assign advance   = in_valid_ff && ((idx_ff != IDX_Y) || pkt_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign pkt.valid  = in_valid_ff && (idx_ff == IDX_Y);
   assign pkt.header = header_ff;
   assign pkt.x_mag  = x_mag_ff;
   assign pkt.y_mag  = in_byte_ff;

   always_comb begin
      idx_in      = idx_ff;
      header_in   = header_ff;
      x_mag_in    = x_mag_ff;
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance) begin
         unique case (idx_ff)
            IDX_HEADER: begin
               header_in = in_byte_ff;
               idx_in    = IDX_X;
            end
            IDX_X: begin
               x_mag_in = in_byte_ff;
               idx_in   = IDX_Y;
            end
            IDX_Y: begin
               idx_in = IDX_HEADER;
            end
            default: begin
               idx_in = IDX_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff      <= IDX_HEADER;
         header_ff   <= '0;
         x_mag_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff      <= idx_in;
         header_ff   <= header_in;
         x_mag_ff    <= x_mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
      end
   end

endmodule

`default_nettype wire

### src/pmct_cursor.sv
// Packet decode, cursor update with clamping, size registers and result register.
// Depends on pmct_pkg; takes packets from pmct_framer.
`default_nettype none

module pmct_cursor
   import pmct_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire packet_type           pkt,
   output      logic                 pkt_ready,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [POS_W-1:0]     rsp_pos_x,
   output      logic [POS_W-1:0]     rsp_pos_y,
   output      logic [DELTA_W-1:0]   rsp_delta_x,
   output      logic [DELTA_W-1:0]   rsp_delta_y,
   output      logic [BTN_W-1:0]     rsp_button_bits
);

   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [CUR_W-1:0]   col_ff, col_in;
   logic [CUR_W-1:0]   row_ff, row_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff;
   logic [DELTA_W-1:0] delta_x_ff, delta_y_ff;
   logic [BTN_W-1:0]   button_ff;

   logic                      take;
   logic                      overflow;
   logic                      csr_hit;
   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic [CUR_W-1:0]          col_move, row_move;

   assign pkt_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pkt.valid && pkt_ready;

   assign overflow = pkt.header[HDR_X_OVF] || pkt.header[HDR_Y_OVF];
   assign dx = overflow ? '0 : decode_delta(pkt.x_mag, pkt.header[HDR_X_SIGN]);
   assign dy = overflow ? '0 : -decode_delta(pkt.y_mag, pkt.header[HDR_Y_SIGN]);

   assign col_move = clamp_coord(col_ff, dx, eff_size(width_ff));
   assign row_move = clamp_coord(row_ff, dy, eff_size(height_ff));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH: begin
               width_in = csr_data;
               csr_hit  = 1'b1;
            end
            CSR_SCREEN_HEIGHT: begin
               height_in = csr_data;
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         // Recenter both axes on any size write.
         col_in = half_size(eff_size(width_in));
         row_in = half_size(eff_size(height_in));
      end else if (take) begin
         col_in = col_move;
         row_in = row_move;
      end
      rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= half_size(eff_size(WIDTH_RESET));
         row_ff       <= half_size(eff_size(HEIGHT_RESET));
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pos_x_ff   <= POS_W'(col_move);
         pos_y_ff   <= POS_W'(row_move);
         delta_x_ff <= dx;
         delta_y_ff <= dy;
         button_ff  <= pkt.header[BTN_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_delta_x     = delta_x_ff;
   assign rsp_delta_y     = delta_y_ff;
   assign rsp_button_bits = button_ff;

endmodule

`default_nettype wire

### src/pmct_checker.sv
// Port-level checks for the PS/2 mouse cursor tracker, bound to the top level.
// Depends on pmct_pkg.
`default_nettype none

module pmct_checker
   import pmct_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [POS_W-1:0]   rsp_pos_x,
   input wire logic [POS_W-1:0]   rsp_pos_y,
   input wire logic [DELTA_W-1:0] rsp_delta_x,
   input wire logic [DELTA_W-1:0] rsp_delta_y
);

   localparam logic [DELTA_W-1:0] DELTA_MIN_NEG = {1'b1, {(DELTA_W-1){1'b0}}};

   // Hold a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y))
      else $error("stalled response changed or dropped");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A zero magnitude never decodes to the most negative delta.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delta_x != DELTA_MIN_NEG) && (rsp_delta_y != DELTA_MIN_NEG))
      else $error("delta of minus 256 reported");

   // A fresh response follows an accepted request through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

endmodule

bind ps2_mouse_packet_cursor_tracker_top pmct_checker u_pmct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_pos_x   (rsp_pos_x),
   .rsp_pos_y   (rsp_pos_y),
   .rsp_delta_x (rsp_delta_x),
   .rsp_delta_y (rsp_delta_y)
);

`default_nettype wire

### tb/sv/tb_ps2_mouse_packet_cursor_tracker_top.sv
// Testbench for the PS/2 mouse packet cursor tracker: a cursor predictor with an event
// scoreboard, plus the top module that drives bytes, size writes and response stalls.
// Depends on pmct_pkg and ps2_mouse_packet_cursor_tracker_top.

package pmct_tb_pkg;
   import pmct_pkg::*;

   typedef struct {
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [BTN_W-1:0]          button_bits;
   } mouse_event_type;

   class cursor_scoreboard;
      logic [SIZE_W-1:0] width_reg;
      logic [SIZE_W-1:0] height_reg;
      byte_idx_type      byte_pos;
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_mag;
      int                col;
      int                row;
      mouse_event_type   awaited_events[$];
      int                errors;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         byte_pos   = IDX_HEADER;
         header     = '0;
         x_mag      = '0;
         errors     = 0;
         recenter();
      endfunction

      function int usable_size(input logic [SIZE_W-1:0] v);
         if (v == 0) return 1;
         if (int'(v) > COORD_LIMIT) return COORD_LIMIT;
         return int'(v);
      endfunction

      function void recenter();
         col = usable_size(width_reg) / 2;
         row = usable_size(height_reg) / 2;
      endfunction

      function int signed_delta(input logic [BYTE_W-1:0] mag, input logic neg);
         int d;
         d = int'(mag);
         // a zero magnitude never turns into -256
         if (d != 0 && neg) d = d - 256;
         return d;
      endfunction

      function int limit_axis(input int v, input int size);
         if (v > size - 1) v = size - 1;
         if (v < 0) v = 0;
         return v;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
         if (idx == CSR_SCREEN_WIDTH) begin
            width_reg = v;
            recenter();
         end else if (idx == CSR_SCREEN_HEIGHT) begin
            height_reg = v;
            recenter();
         end
      endfunction

      // Take one accepted request; the third byte of a group yields one event.
      function void absorb_byte(input logic [BYTE_W-1:0] b);
         int              dx;
         int              dy;
         mouse_event_type ev;
         case (byte_pos)
            IDX_HEADER: begin
               header   = b;
               byte_pos = IDX_X;
            end
            IDX_X: begin
               x_mag    = b;
               byte_pos = IDX_Y;
            end
            default: begin
               byte_pos = IDX_HEADER;
               dx = signed_delta(x_mag, header[HDR_X_SIGN]);
               dy = signed_delta(b, header[HDR_Y_SIGN]);
               if (header[HDR_X_OVF] || header[HDR_Y_OVF]) begin
                  dx = 0;
                  dy = 0;
               end
               dy  = -dy;
               col = limit_axis(col + dx, usable_size(width_reg));
               row = limit_axis(row + dy, usable_size(height_reg));
               ev.pos_x       = POS_W'(col);
               ev.pos_y       = POS_W'(row);
               ev.delta_x     = DELTA_W'(dx);
               ev.delta_y     = DELTA_W'(dy);
               ev.button_bits = header[BTN_W-1:0];
               awaited_events.push_back(ev);
            end
         endcase
      endfunction

      function void compare_field(input string name, input int want, input int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_event(input mouse_event_type got);
         mouse_event_type want;
         if (awaited_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual x=%0d y=%0d",
                     $time, got.pos_x, got.pos_y);
            errors++;
            return;
         end
         want = awaited_events.pop_front();
         compare_field("pos_x", int'(want.pos_x), int'(got.pos_x));
         compare_field("pos_y", int'(want.pos_y), int'(got.pos_y));
         compare_field("delta_x", int'(want.delta_x), int'(got.delta_x));
         compare_field("delta_y", int'(want.delta_y), int'(got.delta_y));
         compare_field("button_bits", int'(want.button_bits), int'(got.button_bits));
      endfunction
   endclass
endpackage

module tb_ps2_mouse_packet_cursor_tracker_top
   import pmct_pkg::*, pmct_tb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_NS     = 3_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [BYTE_W-1:0]         req_data_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [POS_W-1:0]          rsp_pos_x;
   logic [POS_W-1:0]          rsp_pos_y;
   logic signed [DELTA_W-1:0] rsp_delta_x;
   logic signed [DELTA_W-1:0] rsp_delta_y;
   logic [BTN_W-1:0]          rsp_button_bits;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [SIZE_W-1:0]         csr_data = '0;

   cursor_scoreboard tracker;
   int   send_pct = 0;
   int   stall_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   ps2_mouse_packet_cursor_tracker_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_button_bits (rsp_button_bits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off counted here once requested.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      mouse_event_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            tracker.write_reg(csr_index, csr_data);
         end
         if (rsp_valid && rsp_ready) begin
            got.pos_x       = rsp_pos_x;
            got.pos_y       = rsp_pos_y;
            got.delta_x     = rsp_delta_x;
            got.delta_y     = rsp_delta_y;
            got.button_bits = rsp_button_bits;
            tracker.check_event(got);
         end
         if (req_valid && req_ready) begin
            tracker.absorb_byte(req_data_byte);
         end
      end
   end

   // Leave valid high between back-to-back requests; drop it only for a gap.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
      wait_drained();
      // let a header or X byte still in flight settle before the write
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
   endtask

   function automatic logic [BYTE_W-1:0] pick_mag();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r <= 3) return BYTE_W'($urandom_range(8, 1));
      if (r == 4) return ($urandom_range(1) != 0) ? 8'hFF : 8'h80;
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic send_packet(input int x_neg_pct, input int y_neg_pct, input int ovf_pct);
      logic [BYTE_W-1:0] hdr;
      hdr = BYTE_W'($urandom_range(255));
      if ($urandom_range(99) >= ovf_pct) begin
         hdr[HDR_X_OVF] = 1'b0;
         hdr[HDR_Y_OVF] = 1'b0;
      end
      hdr[HDR_X_SIGN] = ($urandom_range(99) < x_neg_pct);
      hdr[HDR_Y_SIGN] = ($urandom_range(99) < y_neg_pct);
      send_byte(hdr);
      send_byte(pick_mag());
      send_byte(pick_mag());
   endtask

   // Mostly whole packets; now and then a stray byte shifts the framing.
   task automatic run_packets(input int count, input int x_neg_pct, input int y_neg_pct,
                              input int ovf_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 4) begin
            send_byte(BYTE_W'($urandom_range(255)));
         end
         send_packet(x_neg_pct, y_neg_pct, ovf_pct);
      end
   endtask

   task automatic set_idle(input int s, input int r);
      send_pct  <= s;
      stall_pct <= r;
   endtask

   initial begin
      logic [BYTE_W-1:0] opening[$];
      opening = '{8'h07, 8'h00, 8'h00,   // all buttons, no move
                  8'h30, 8'h00, 8'h00,   // sign bits with zero magnitude
                  8'h08, 8'hFF, 8'hFF,   // largest positive moves
                  8'h38, 8'h01, 8'h01,   // largest negative moves
                  8'h78, 8'hFF, 8'hFF,   // X overflow
                  8'h88, 8'h80, 8'h80,   // Y overflow
                  8'hC7, 8'h12, 8'h34,   // both overflow bits
                  8'h3B, 8'hFF, 8'hFF};  // minus one on both axes
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_byte(opening[i]);

      run_packets(34, 50, 50, 10);

      set_screen(13'd1, 13'd1);
      set_idle(48, 0);
      run_packets(34, 50, 50, 10);

      set_screen(13'd0, 13'd0);
      set_idle(0, 48);
      run_packets(34, 50, 50, 10);

      // oversize values act as the limit; drift toward one corner, then the opposite one
      set_screen(13'd8191, 13'd4097);
      set_idle(17, 17);
      run_packets(20, 5, 95, 5);
      run_packets(20, 95, 5, 5);

      // unknown indexes change nothing
      write_csr(CSR_IDX_W'(15), 13'd8191);
      write_csr(CSR_IDX_W'(2), 13'd0);
      set_screen(13'd4096, 13'd4096);
      set_idle(0, 0);
      hold_toggle <= ~hold_toggle;
      run_packets(30, 50, 50, 10);

      set_screen(13'd3, 13'd5);
      run_packets(20, 50, 50, 10);

      set_screen(SIZE_W'($urandom_range(4096, 1)), SIZE_W'($urandom_range(4096, 1)));
      set_idle(48, 0);
      run_packets(34, 50, 50, 10);

      set_screen(13'd640, 13'd480);
      set_idle(0, 48);
      run_packets(34, 50, 50, 10);

      set_screen(SIZE_W'($urandom_range(64, 1)), SIZE_W'($urandom_range(64, 1)));
      set_idle(17, 17);
      run_packets(17, 50, 50, 10);
      // hold the sender until every event is back, then carry on
      wait_drained();
      run_packets(17, 50, 50, 10);

      wait_drained();
      repeat (DRAIN_CYCLES * 3) @(posedge clock);
      if (tracker.errors == 0 && tracker.awaited_events.size() == 0) begin
         $display("tb_ps2_mouse_packet_cursor_tracker_top passed");
      end else begin
         $display("tb_ps2_mouse_packet_cursor_tracker_top failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_ps2_mouse_packet_cursor_tracker_top failed");
      $finish;
   end

endmodule
